/* rtl/core/fpsc_pkg.sv */
// Package: shared types and codes of the passive-serial configuration controller.
`default_nettype none
package fpsc_pkg;

  localparam int unsigned DelayWidth = 20;
  localparam int unsigned PollWidth  = 16;
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = DelayWidth;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxWidth-1:0] CFG_USE_CONF_DONE  = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_RESET_DELAY    = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_START_POLL_LIM = 2'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_END_POLL_LIM   = 2'd3;

  localparam logic                  USE_CONF_DONE_RST  = 1'b1;
  localparam logic [DelayWidth-1:0] RESET_DELAY_RST    = 20'd10000;
  localparam logic [PollWidth-1:0]  START_POLL_LIM_RST = 16'd200;
  localparam logic [PollWidth-1:0]  END_POLL_LIM_RST   = 16'hffff;

  // Commands.
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_START  = 3'd1;
  localparam logic [2:0] OP_BYTE   = 3'd2;
  localparam logic [2:0] OP_FINISH = 3'd3;
  localparam logic [2:0] OP_CLEAN  = 3'd4;

  // Outcome codes.
  localparam logic [1:0] OUTCOME_NONE = 2'd0;
  localparam logic [1:0] OUTCOME_OK   = 2'd1;
  localparam logic [1:0] OUTCOME_FAIL = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_NSTATUS_HIGH = 3'd1;
  localparam logic [2:0] ERR_CONFDONE_HI  = 3'd2;
  localparam logic [2:0] ERR_NSTATUS_LOW  = 3'd3;
  localparam logic [2:0] ERR_CONFDONE_LO  = 3'd4;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] data_byte;
    logic       nstatus_in;
    logic       conf_done_in;
  } cmd_item_t;

  typedef struct packed {
    logic       nconfig_level;
    logic       dclk_level;
    logic       data_level;
    logic       byte_taken;
    logic       busy_res;
    logic [1:0] outcome;
    logic [2:0] error_code;
  } res_item_t;

endpackage
`default_nettype wire

/* rtl/core/fpsc_chan.sv */
// Interface: valid/ready channel carrying one request payload.
`default_nettype none
interface fpsc_chan #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/core/fpga_passive_serial_configurator_unit.sv */
// Top level: passive-serial FPGA configuration controller, one tick per request.
//
//   channel | direction | payload                 | handshake
//   cmd     | in        | fpsc_pkg::cmd_item_t    | valid / ready
//   res     | out       | fpsc_pkg::res_item_t    | valid / ready
//   cfg     | in        | cfg_index, cfg_wdata    | cfg_we, no stall
//
// Every accepted command request updates the controller state in the same cycle and
// loads the pin levels and status into the result register; one request per cycle while not stalled.
// The result register is the only stall point: cmd is ready while it is empty or
// being drained. Reset (rst, synchronous) returns the controller to idle with nCONFIG
// high and the registers at their default values; no clearing pass is needed.
`default_nettype none
module fpga_passive_serial_configurator_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  fpsc_chan.sink                                  cmd,
  fpsc_chan.source                                res,
  input  wire logic                               cfg_we,
  input  wire logic [fpsc_pkg::CfgIdxWidth-1:0]   cfg_index,
  input  wire logic [fpsc_pkg::CfgDataWidth-1:0]  cfg_wdata
);
  import fpsc_pkg::*;

  typedef enum logic [11:0] {
    PH_IDLE    = 12'b0000_0000_0001,
    PH_PRE     = 12'b0000_0000_0010,
    PH_LOW     = 12'b0000_0000_0100,
    PH_NS_LOW  = 12'b0000_0000_1000,
    PH_CD_LOW  = 12'b0000_0001_0000,
    PH_NS_HIGH = 12'b0000_0010_0000,
    PH_READY   = 12'b0000_0100_0000,
    PH_SHIFT   = 12'b0000_1000_0000,
    PH_CD_HIGH = 12'b0001_0000_0000,
    PH_CLEAN   = 12'b0010_0000_0000,
    PH_OK      = 12'b0100_0000_0000,
    PH_FAIL    = 12'b1000_0000_0000
  } phase_t;

  logic                  use_conf_done;
  logic [DelayWidth-1:0] reset_delay_ticks;
  logic [PollWidth-1:0]  start_poll_limit;
  logic [PollWidth-1:0]  end_poll_limit;

  phase_t                phase, phase_next;
  logic [DelayWidth-1:0] wait_counter, wait_counter_next;
  logic [7:0]            shift_byte, shift_byte_next;
  logic [2:0]            bit_index, bit_index_next;
  logic                  clock_half, clock_half_next;
  logic                  nconfig_drive, nconfig_drive_next;
  logic                  data_drive, data_drive_next;
  logic [2:0]            last_error, last_error_next;

  logic                  res_valid;
  res_item_t             res_payload, res_payload_next;

  logic                  accept;
  logic                  idle_like;
  logic                  idle_like_next;
  logic                  taken;
  logic [DelayWidth-1:0] bound;
  logic [DelayWidth-1:0] bound_eff;
  logic [DelayWidth:0]   cnt_inc;
  logic                  bound_hit;
  logic [DelayWidth-1:0] cnt_after;

  assign cmd.ready   = !res_valid || res.ready;
  assign accept      = cmd.valid && cmd.ready;
  assign res.valid   = res_valid;
  assign res.payload = res_payload;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_conf_done     <= USE_CONF_DONE_RST;
      reset_delay_ticks <= RESET_DELAY_RST;
      start_poll_limit  <= START_POLL_LIM_RST;
      end_poll_limit    <= END_POLL_LIM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_USE_CONF_DONE:  use_conf_done     <= cfg_wdata[0];
        CFG_RESET_DELAY:    reset_delay_ticks <= cfg_wdata[DelayWidth-1:0];
        CFG_START_POLL_LIM: start_poll_limit  <= cfg_wdata[PollWidth-1:0];
        CFG_END_POLL_LIM:   end_poll_limit    <= cfg_wdata[PollWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  // The single tick counter is shared by all delays and waits; the bound follows the phase.
  always_comb begin
    case (phase)
      PH_PRE, PH_LOW, PH_CLEAN:         bound = reset_delay_ticks;
      PH_NS_LOW, PH_CD_LOW, PH_NS_HIGH: bound = {{(DelayWidth-PollWidth){1'b0}}, start_poll_limit};
      PH_CD_HIGH:                       bound = {{(DelayWidth-PollWidth){1'b0}}, end_poll_limit};
      default:                          bound = reset_delay_ticks;
    endcase
    bound_eff = (bound == '0) ? {{(DelayWidth-1){1'b0}}, 1'b1} : bound;
    cnt_inc   = {1'b0, wait_counter} + {{DelayWidth{1'b0}}, 1'b1};
    bound_hit = cnt_inc >= {1'b0, bound_eff};
    cnt_after = bound_hit ? '0 : cnt_inc[DelayWidth-1:0];
  end

  always_comb begin
    phase_next         = phase;
    wait_counter_next  = wait_counter;
    shift_byte_next    = shift_byte;
    bit_index_next     = bit_index;
    clock_half_next    = clock_half;
    nconfig_drive_next = nconfig_drive;
    data_drive_next    = data_drive;
    last_error_next    = last_error;
    taken              = 1'b0;
    idle_like = (phase == PH_IDLE) || (phase == PH_OK) || (phase == PH_FAIL)
             || (phase == PH_READY);

    if (idle_like && cmd.payload.opcode == OP_START) begin
      nconfig_drive_next = 1'b1;
      clock_half_next    = 1'b0;
      last_error_next    = ERR_NONE;
      wait_counter_next  = '0;
      phase_next         = PH_PRE;
    end else if (idle_like && cmd.payload.opcode == OP_CLEAN) begin
      nconfig_drive_next = 1'b0;
      last_error_next    = ERR_NONE;
      wait_counter_next  = '0;
      phase_next         = PH_CLEAN;
    end else if (phase == PH_READY && cmd.payload.opcode == OP_BYTE) begin
      taken           = 1'b1;
      shift_byte_next = cmd.payload.data_byte;
      bit_index_next  = 3'd0;
      clock_half_next = 1'b0;
      data_drive_next = cmd.payload.data_byte[0];
      phase_next      = PH_SHIFT;
    end else if (phase == PH_READY && cmd.payload.opcode == OP_FINISH) begin
      wait_counter_next = '0;
      phase_next        = use_conf_done ? PH_CD_HIGH : PH_OK;
    end else begin
      case (phase)
        PH_PRE: begin
          wait_counter_next = cnt_after;
          if (bound_hit) begin
            nconfig_drive_next = 1'b0;
            phase_next         = PH_LOW;
          end
        end
        PH_LOW: begin
          wait_counter_next = cnt_after;
          if (bound_hit) phase_next = PH_NS_LOW;
        end
        PH_NS_LOW: begin
          if (!cmd.payload.nstatus_in) begin
            wait_counter_next = '0;
            if (use_conf_done) begin
              phase_next = PH_CD_LOW;
            end else begin
              nconfig_drive_next = 1'b1;
              phase_next         = PH_NS_HIGH;
            end
          end else begin
            wait_counter_next = cnt_after;
            if (bound_hit) begin
              last_error_next = ERR_NSTATUS_HIGH;
              phase_next      = PH_FAIL;
            end
          end
        end
        PH_CD_LOW: begin
          if (!cmd.payload.conf_done_in) begin
            wait_counter_next  = '0;
            nconfig_drive_next = 1'b1;
            phase_next         = PH_NS_HIGH;
          end else begin
            wait_counter_next = cnt_after;
            if (bound_hit) begin
              last_error_next = ERR_CONFDONE_HI;
              phase_next      = PH_FAIL;
            end
          end
        end
        PH_NS_HIGH: begin
          if (cmd.payload.nstatus_in) begin
            wait_counter_next = '0;
            phase_next        = PH_READY;
          end else begin
            wait_counter_next = cnt_after;
            if (bound_hit) begin
              last_error_next = ERR_NSTATUS_LOW;
              phase_next      = PH_FAIL;
            end
          end
        end
        PH_SHIFT: begin
          if (!clock_half) begin
            clock_half_next = 1'b1;
          end else begin
            clock_half_next = 1'b0;
            if (bit_index == 3'd7) begin
              bit_index_next = 3'd0;
              phase_next     = PH_READY;
            end else begin
              bit_index_next  = bit_index + 3'd1;
              data_drive_next = shift_byte[bit_index_next];
            end
          end
        end
        PH_CD_HIGH: begin
          if (cmd.payload.conf_done_in) begin
            wait_counter_next = '0;
            phase_next        = PH_OK;
          end else begin
            wait_counter_next = cnt_after;
            if (bound_hit) begin
              last_error_next = ERR_CONFDONE_LO;
              phase_next      = PH_FAIL;
            end
          end
        end
        PH_CLEAN: begin
          wait_counter_next = cnt_after;
          if (bound_hit) begin
            nconfig_drive_next = 1'b1;
            phase_next         = PH_IDLE;
          end
        end
        default: begin
        end
      endcase
    end

    idle_like_next = (phase_next == PH_IDLE) || (phase_next == PH_OK)
                  || (phase_next == PH_FAIL) || (phase_next == PH_READY);
    res_payload_next.nconfig_level = nconfig_drive_next;
    res_payload_next.dclk_level    = clock_half_next;
    res_payload_next.data_level    = data_drive_next;
    res_payload_next.byte_taken    = taken;
    res_payload_next.busy_res      = !idle_like_next;
    res_payload_next.outcome       = (phase_next == PH_OK)   ? OUTCOME_OK
                                   : (phase_next == PH_FAIL) ? OUTCOME_FAIL : OUTCOME_NONE;
    res_payload_next.error_code    = last_error_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      wait_counter  <= '0;
      shift_byte    <= '0;
      bit_index     <= '0;
      clock_half    <= 1'b0;
      nconfig_drive <= 1'b1;
      data_drive    <= 1'b0;
      last_error    <= ERR_NONE;
      res_valid     <= 1'b0;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        wait_counter  <= wait_counter_next;
        shift_byte    <= shift_byte_next;
        bit_index     <= bit_index_next;
        clock_half    <= clock_half_next;
        nconfig_drive <= nconfig_drive_next;
        data_drive    <= data_drive_next;
        last_error    <= last_error_next;
        res_valid     <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) res_payload <= res_payload_next;
  end

endmodule
`default_nettype wire

/* rtl/core/fpsc_checker.sv */
// Checker: port-level assertions on the configuration controller, bound to the top level.
`default_nettype none
module fpsc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic       dclk_level,
  input wire logic       byte_taken,
  input wire logic       busy_res,
  input wire logic [1:0] outcome,
  input wire logic [2:0] error_code
);
  import fpsc_pkg::*;

  // A result that is not taken stays offered.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result request dropped while stalled");

  // Taking a byte starts a shift, with DCLK still low.
  a_byte_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && byte_taken |-> busy_res && !dclk_level)
    else $error("byte taken without starting a low-DCLK shift");

  // A final outcome is only reported when nothing is in progress.
  a_outcome_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && outcome != OUTCOME_NONE |-> !busy_res)
    else $error("outcome reported while busy");

  // An error code is only ever held together with a failed outcome.
  a_error_fail: assert property (@(posedge clk) disable iff (rst)
    res_valid && error_code != ERR_NONE |-> outcome == OUTCOME_FAIL)
    else $error("error code without failure outcome");

endmodule

bind fpga_passive_serial_configurator_unit fpsc_checker u_fpsc_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .dclk_level (res.payload.dclk_level),
  .byte_taken (res.payload.byte_taken),
  .busy_res   (res.payload.busy_res),
  .outcome    (res.payload.outcome),
  .error_code (res.payload.error_code)
);
`default_nettype wire
